// ----- design/glf_pkg.sv -----
// ----------------------------------------------------------------------------
// glf_pkg - shared types, constants and row rule for the toroidal life block
// Board geometry, register map, controller states and the row update function.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package glf_pkg;

	localparam int MAX_ROWS = 64;
	localparam int MAX_COLS = 64;
	localparam int ROW_W    = 64;
	localparam int IDX_W    = $clog2(MAX_ROWS);
	localparam int CNT_W    = 7;
	localparam int GEN_W    = 16;
	localparam int ADDR_W   = 4;
	localparam int DATA_W   = 32;

	typedef logic [ROW_W-1:0] row_t;

	// register indexes (byte address is 4 * index)
	typedef enum logic [1:0] {
		REG_ROW_COUNT = 2'd0,
		REG_COL_COUNT = 2'd1,
		REG_GEN_COUNT = 2'd2,
		REG_NONE      = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		S_LOAD,
		S_GSTART,
		S_GRUN,
		S_OUT
	} state_t;

	// per-cell control from the sequencer
	typedef struct packed {
		logic load;
		logic shift;
	} cell_ctl_t;

	// mask of the columns in use, n in 1..64
	function automatic row_t col_mask(input logic [CNT_W-1:0] n);
		row_t m;
		if (n >= CNT_W'(MAX_COLS)) begin
			m = '1;
		end else begin
			m = (row_t'(1) << n) - row_t'(1);
		end
		return m;
	endfunction

	// bit j takes bit (j-1 mod n)
	function automatic row_t from_west(input row_t x, input logic [CNT_W-1:0] n);
		row_t r;
		logic [IDX_W-1:0] top;
		top = IDX_W'(n - CNT_W'(1));
		for (int j = 0; j < ROW_W; j++) begin
			if (j == 0) begin
				r[j] = x[top];
			end else begin
				r[j] = x[j-1];
			end
		end
		return r;
	endfunction

	// bit j takes bit (j+1 mod n)
	function automatic row_t from_east(input row_t x, input logic [CNT_W-1:0] n);
		row_t r;
		logic [IDX_W-1:0] top;
		top = IDX_W'(n - CNT_W'(1));
		for (int j = 0; j < ROW_W; j++) begin
			if (IDX_W'(j) == top) begin
				r[j] = x[0];
			end else if (j < ROW_W - 1) begin
				r[j] = x[j+1];
			end else begin
				r[j] = 1'b0;
			end
		end
		return r;
	endfunction

	// next generation of one row from its masked neighbor rows
	function automatic row_t next_row(input row_t up, input row_t mid, input row_t down,
			input logic [CNT_W-1:0] n, input row_t m);
		row_t uw, ue, mw, me, dw, de, r;
		logic [3:0] c;
		uw = from_west(up, n) & m;
		ue = from_east(up, n) & m;
		mw = from_west(mid, n) & m;
		me = from_east(mid, n) & m;
		dw = from_west(down, n) & m;
		de = from_east(down, n) & m;
		for (int j = 0; j < ROW_W; j++) begin
			c = 4'(uw[j]) + 4'(up[j]) + 4'(ue[j]) + 4'(mw[j]) + 4'(me[j])
				+ 4'(dw[j]) + 4'(down[j]) + 4'(de[j]);
			r[j] = (c == 4'd3) || ((c == 4'd2) && mid[j]);
		end
		return r & m;
	endfunction

endpackage
`default_nettype wire

// ----- design/glf_if.sv -----
// ----------------------------------------------------------------------------
// glf_in_if / glf_out_if - item channels of the toroidal life block
// Valid/ready channels carrying board rows in and result rows out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface glf_in_if;
	logic            valid;
	logic            ready;
	glf_pkg::row_t   row_bits;
	logic            last_row;
	modport source (output valid, output row_bits, output last_row, input ready);
	modport sink (input valid, input row_bits, input last_row, output ready);
endinterface

interface glf_out_if;
	logic            valid;
	logic            ready;
	glf_pkg::row_t   result_row;
	logic            final_row;
	modport source (output valid, output result_row, output final_row, input ready);
	modport sink (input valid, input result_row, input final_row, output ready);
endinterface
`default_nettype wire

// ----- design/glf_cell.sv -----
// ----------------------------------------------------------------------------
// glf_cell - one board row of the rotating row chain
// Holds a row; takes a loaded row or the row from its neighbor when shifted.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module glf_cell (
	input  wire                 clk,
	input  glf_pkg::cell_ctl_t  ctl,
	input  glf_pkg::row_t       load_row,
	input  glf_pkg::row_t       shift_in,
	output glf_pkg::row_t       row
);
	glf_pkg::row_t row_q;

	// load from input, or advance along the chain
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			row_q <= load_row;
		end else if (ctl.shift) begin
			row_q <= shift_in;
		end
	end

	assign row = row_q;
endmodule
`default_nettype wire

// ----- design/toroidal_life_generations_top.sv -----
// Sequence: after the last row, each generation passes S_GSTART and then walks the
// rows in S_GRUN; then row_count result items follow, one per cycle while the sink is ready.
// Throughput: rows load one per cycle; one board at a time, set by the single row
// update unit that walks the rotating row chain once per generation.
// Reset: controller, counters and registers clear (64 rows, 64 cols, 1 generation);
// board rows are not reset.
// ----------------------------------------------------------------------------
// toroidal_life_generations_top - toroidal Game of Life engine
// Loads a board, runs generations on a chain of row cells, streams the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module toroidal_life_generations_top (
	input  wire                          clk,
	input  wire                          arst_n,
	glf_in_if.sink                       rows_in,
	glf_out_if.source                    rows_out,
	input  wire                          psel,
	input  wire                          penable,
	input  wire                          pwrite,
	input  wire  [glf_pkg::ADDR_W-1:0]   paddr,
	input  wire  [glf_pkg::DATA_W-1:0]   pwdata,
	output logic [glf_pkg::DATA_W-1:0]   prdata,
	output logic                         pready
);
	localparam int NR = glf_pkg::MAX_ROWS;
	localparam int CW = glf_pkg::CNT_W;
	localparam int GW = glf_pkg::GEN_W;

	logic [CW-1:0] row_count_q, col_count_q;
	logic [GW-1:0] gen_count_q;
	logic [CW-1:0] load_idx_q;
	logic [CW-1:0] k_q;
	logic [GW-1:0] gen_q;
	glf_pkg::state_t state_q, state_nx;
	glf_pkg::row_t north_q, first_q;
	glf_pkg::row_t rows [NR];
	glf_pkg::row_t feed, south, new_row, mask, tail_row;
	logic [CW-1:0] nr, nc;
	glf_pkg::reg_idx_t widx;
	logic in_acc, out_acc, cfg_wr, k_last, gen_last;

	// configuration port
	assign pready = 1'b1;
	assign widx   = glf_pkg::reg_idx_t'(paddr[3:2]);
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q <= CW'(64);
			col_count_q <= CW'(64);
			gen_count_q <= GW'(1);
		end else if (cfg_wr) begin
			case (widx)
				glf_pkg::REG_ROW_COUNT: row_count_q <= pwdata[CW-1:0];
				glf_pkg::REG_COL_COUNT: col_count_q <= pwdata[CW-1:0];
				glf_pkg::REG_GEN_COUNT: gen_count_q <= pwdata[GW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (widx)
			glf_pkg::REG_ROW_COUNT: prdata = glf_pkg::DATA_W'(row_count_q);
			glf_pkg::REG_COL_COUNT: prdata = glf_pkg::DATA_W'(col_count_q);
			glf_pkg::REG_GEN_COUNT: prdata = glf_pkg::DATA_W'(gen_count_q);
			default:                prdata = '0;
		endcase
	end

	// clamp geometry
	always_comb begin
		if (row_count_q == '0) nr = CW'(1);
		else if (row_count_q > CW'(NR)) nr = CW'(NR);
		else nr = row_count_q;
		if (col_count_q == '0) nc = CW'(1);
		else if (col_count_q > CW'(glf_pkg::MAX_COLS)) nc = CW'(glf_pkg::MAX_COLS);
		else nc = col_count_q;
	end
	assign mask = glf_pkg::col_mask(nc);

	assign in_acc   = rows_in.valid && rows_in.ready;
	assign out_acc  = rows_out.valid && rows_out.ready;
	assign k_last   = (k_q == nr - CW'(1));
	assign gen_last = (gen_q == gen_count_q - GW'(1));

	// row update unit: current row sits in cell 0
	assign tail_row = rows[glf_pkg::IDX_W'(nr - CW'(1))];
	assign south    = k_last ? first_q : rows[1];
	assign new_row  = glf_pkg::next_row(north_q & mask, rows[0] & mask, south & mask,
		nc, mask);
	assign feed     = (state_q == glf_pkg::S_GRUN) ? new_row : rows[0];

	// row chain
	for (genvar i = 0; i < NR; i++) begin : g_cell
		glf_pkg::cell_ctl_t ctl;
		glf_pkg::row_t      sin;
		always_comb begin
			ctl.load  = in_acc && (load_idx_q == CW'(i));
			ctl.shift = ((state_q == glf_pkg::S_GRUN) || out_acc) && (CW'(i) < nr);
		end
		if (i == NR - 1) begin : g_end
			assign sin = feed;
		end else begin : g_mid
			assign sin = (CW'(i) == nr - CW'(1)) ? feed : rows[i+1];
		end
		glf_cell u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.load_row (rows_in.row_bits),
			.shift_in (sin),
			.row      (rows[i])
		);
	end

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			glf_pkg::S_LOAD: begin
				if (in_acc && rows_in.last_row) begin
					state_nx = (gen_count_q == '0) ? glf_pkg::S_OUT : glf_pkg::S_GSTART;
				end
			end
			glf_pkg::S_GSTART: state_nx = glf_pkg::S_GRUN;
			glf_pkg::S_GRUN: begin
				if (k_last) begin
					state_nx = gen_last ? glf_pkg::S_OUT : glf_pkg::S_GSTART;
				end
			end
			glf_pkg::S_OUT: begin
				if (out_acc && k_last) state_nx = glf_pkg::S_LOAD;
			end
			default: state_nx = glf_pkg::S_LOAD;
		endcase
	end

	// outputs
	always_comb begin
		rows_in.ready       = (state_q == glf_pkg::S_LOAD);
		rows_out.valid      = (state_q == glf_pkg::S_OUT);
		rows_out.result_row = rows[0] & mask;
		rows_out.final_row  = k_last;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= glf_pkg::S_LOAD;
			load_idx_q <= '0;
			k_q        <= '0;
			gen_q      <= '0;
		end else begin
			state_q <= state_nx;
			if (in_acc) begin
				if (rows_in.last_row) load_idx_q <= '0;
				else if (load_idx_q < CW'(NR)) load_idx_q <= load_idx_q + CW'(1);
			end
			if (state_q == glf_pkg::S_GSTART) begin
				k_q <= '0;
			end else if (state_q == glf_pkg::S_GRUN) begin
				k_q <= k_last ? '0 : k_q + CW'(1);
				if (k_last) gen_q <= gen_last ? '0 : gen_q + GW'(1);
			end else if (out_acc) begin
				k_q <= k_last ? '0 : k_q + CW'(1);
			end
		end
	end

	// neighbor rows held across the in-place walk
	always_ff @(posedge clk) begin
		if (state_q == glf_pkg::S_GSTART) begin
			north_q <= tail_row;
			first_q <= rows[0];
		end else if (state_q == glf_pkg::S_GRUN) begin
			north_q <= rows[0];
		end
	end

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(rows_in.ready && rows_out.valid))
		else $error("input and output active together");
	a_k_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == glf_pkg::S_GRUN || state_q == glf_pkg::S_OUT) |-> (k_q < nr))
		else $error("row counter out of range");
	a_gen_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == glf_pkg::S_GRUN) |-> (gen_q < gen_count_q))
		else $error("generation counter out of range");
	a_back_to_load: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && rows_out.final_row) |=> (rows_in.ready && load_idx_q == '0))
		else $error("no return to load after last row");
endmodule
`default_nettype wire
